// ----- src/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg
// Types and constants shared by the matrix multiply engine and its submodules.
// ----------------------------------------------------------------------------
package mme_pkg;

  // Fixed field widths of the stream payloads.
  localparam int IDX_W  = 3;   // row and column fields
  localparam int VAL_W  = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 product of two elements
  localparam int SUM_W  = 35;  // Q19.16 sum of up to eight products
  localparam int CMD_W  = 2;
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 24;  // row, col, value, padded to bytes
  localparam int OUT_DATA_W = 48;  // row, col, sum, padded to bytes

  // Command codes carried in in_tuser.
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  // Control that travels with each pair of operands through the MAC pipeline.
  typedef struct packed {
    logic vld;    // operand read issued this cycle
    logic first;  // first term of a dot product
    logic last;   // last term of a dot product
  } mac_ctl_t;

endpackage

// ----- src/mme_mem.sv -----
// ----------------------------------------------------------------------------
// mme_mem
// Single-port-write, single-port-read synchronous memory with registered read.
// ----------------------------------------------------------------------------
module mme_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 16
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/mme_mac.sv -----
// ----------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate datapath: registered product, then a 35-bit accumulator
// that holds a finished dot product until the controller takes it.
// ----------------------------------------------------------------------------
module mme_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mme_pkg::mac_ctl_t            issue,    // control of the read issued now
  input  logic [mme_pkg::VAL_W-1:0]    a_data,   // memory read data, from the read issued the cycle before
  input  logic [mme_pkg::VAL_W-1:0]    b_data,
  input  logic                         take,     // controller consumes the result
  output logic                         acc_vld,
  output logic [mme_pkg::SUM_W-1:0]    acc_sum
);
  import mme_pkg::*;

  mac_ctl_t                   ctl1_r;
  mac_ctl_t                   ctl2_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    acc_r;
  logic                       acc_vld_r;
  logic signed [SUM_W-1:0]    prod_ext;

  assign prod_ext = SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r    <= '0;
      ctl2_r    <= '0;
      acc_vld_r <= 1'b0;
    end else begin
      ctl1_r <= issue;
      ctl2_r <= ctl1_r;
      if (ctl2_r.vld && ctl2_r.last) begin
        acc_vld_r <= 1'b1;
      end else if (take) begin
        acc_vld_r <= 1'b0;
      end
    end
    // Payload registers.
    prod_r <= $signed(a_data) * $signed(b_data);
    if (ctl2_r.vld) begin
      acc_r <= ctl2_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  assign acc_vld = acc_vld_r;
  assign acc_sum = acc_r;

endmodule

// ----- src/matrix_multiply_engine.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Fixed-point general matrix multiply C = A x B over two element memories.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries three kinds of transfer, chosen by in_tuser. A
// load of A or B writes one Q8.8 element into its memory at row*MAX_DIM+col
// and is taken one per cycle while the block is idle; loads outside the
// MAX_DIM grid are dropped. A start transfer multiplies the a_rows x
// inner_len matrix A by the inner_len x b_cols matrix B and streams every
// element of C in row-major order on the output, with out_tlast on the
// final element. Sizes come from the configuration port; a size of zero
// acts as one and a size above MAX_DIM acts as MAX_DIM. Write
// configuration only while the block is idle. Each C element is read as
// inner_len terms on the two memory ports (one term per cycle), then
// drains through the read register, the product register and the
// accumulator, after which the sum moves to the output register. While a
// start is being worked on, in_tready stays low. A stalled receiver holds
// the output register; the accumulator then keeps the next element and
// the sequencer waits, so nothing is lost. Synchronous active-low reset
// returns the sizes to defaults of 8 and empties the pipeline; memory
// contents are undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata from bit 0: row[2:0], col[5:3], value[21:6], zero pad[23:22]
  input  logic [mme_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [mme_pkg::CMD_W-1:0]           in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata from bit 0: out_row[2:0], out_col[5:3], dot_sum[40:6], pad[47:41]
  output logic [mme_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  // Configuration write port.
  input  logic                                cfg_wen,
  input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]           cfg_wdata
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM);
  localparam logic [CFG_W-1:0] DIM_CFG  = CFG_W'(MAX_DIM);
  localparam logic [AW-1:0]    DIM_ADDR = AW'(MAX_DIM);
  localparam logic [DW-1:0]    DIM_TOP  = DW'(MAX_DIM - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  // Maps a raw size register to its clamped value minus one.
  function automatic logic [DW-1:0] dim_m1(input logic [CFG_W-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > DIM_CFG) begin
      res = DIM_TOP;
    end else begin
      res = DW'(v - CFG_W'(1));
    end
    return res;
  endfunction

  // Input fields.
  logic [IDX_W-1:0] in_row;
  logic [IDX_W-1:0] in_col;
  logic [VAL_W-1:0] in_value;
  logic             in_xfer;
  logic             load_ok;
  logic [AW-1:0]    load_addr;
  logic             we_a;
  logic             we_b;
  logic             start_xfer;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[21:6];
  assign in_xfer  = in_tvalid && in_tready;
  assign load_ok  = (CFG_W'(in_row) < DIM_CFG) && (CFG_W'(in_col) < DIM_CFG);
  assign load_addr = AW'(in_row[DW-1:0]) * DIM_ADDR + AW'(in_col[DW-1:0]);
  assign we_a = in_xfer && load_ok && (in_tuser == CMD_LOAD_A);
  assign we_b = in_xfer && load_ok && (in_tuser == CMD_LOAD_B);
  assign start_xfer = in_xfer && (in_tuser == CMD_START);

  // Configuration registers, raw as written.
  logic [CFG_W-1:0] a_rows_r;
  logic [CFG_W-1:0] inner_len_r;
  logic [CFG_W-1:0] b_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r    <= CFG_W'(8);
      inner_len_r <= CFG_W'(8);
      b_cols_r    <= CFG_W'(8);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_A_ROWS:    a_rows_r    <= cfg_wdata;
        CFG_INNER_LEN: inner_len_r <= cfg_wdata;
        CFG_B_COLS:    b_cols_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state and output register.
  state_t           state_r, state_nxt;
  logic [DW-1:0]    i_r, i_nxt;
  logic [DW-1:0]    j_r, j_nxt;
  logic [DW-1:0]    k_r, k_nxt;
  logic [DW-1:0]    nr_m1_r, nr_m1_nxt;
  logic [DW-1:0]    nk_m1_r, nk_m1_nxt;
  logic [DW-1:0]    nc_m1_r, nc_m1_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0] out_row_r, out_row_nxt;
  logic [IDX_W-1:0] out_col_r, out_col_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_last_r, out_last_nxt;

  mac_ctl_t         issue;
  logic             acc_take;
  logic             acc_vld;
  logic [SUM_W-1:0] acc_sum;
  logic [AW-1:0]    a_raddr;
  logic [AW-1:0]    b_raddr;
  logic [VAL_W-1:0] a_rdata;
  logic [VAL_W-1:0] b_rdata;
  logic             last_elem;

  // A term of C[i][j] reads A[i][k] and B[k][j]. Memories are written only in
  // the idle state and read only while running, so a load directly before a
  // start lands before the first read and no forwarding is needed.
  assign a_raddr = AW'(i_r) * DIM_ADDR + AW'(k_r);
  assign b_raddr = AW'(k_r) * DIM_ADDR + AW'(j_r);
  assign last_elem = (i_r == nr_m1_r) && (j_r == nc_m1_r);

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    nr_m1_nxt    = nr_m1_r;
    nk_m1_nxt    = nk_m1_r;
    nc_m1_nxt    = nc_m1_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_sum_nxt  = out_sum_r;
    out_last_nxt = out_last_r;
    issue        = '0;
    acc_take     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start_xfer) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          nr_m1_nxt = dim_m1(a_rows_r);
          nk_m1_nxt = dim_m1(inner_len_r);
          nc_m1_nxt = dim_m1(b_cols_r);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        issue.vld   = 1'b1;
        issue.first = (k_r == '0);
        issue.last  = (k_r == nk_m1_r);
        if (k_r == nk_m1_r) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + DW'(1);
        end
      end
      S_WAIT: begin
        // Hand the finished sum to the output register once it is free.
        if (acc_vld && (!out_vld_r || out_tready)) begin
          acc_take     = 1'b1;
          out_vld_nxt  = 1'b1;
          out_row_nxt  = IDX_W'(i_r);
          out_col_nxt  = IDX_W'(j_r);
          out_sum_nxt  = acc_sum;
          out_last_nxt = last_elem;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RUN;
            if (j_r == nc_m1_r) begin
              j_nxt = '0;
              i_nxt = i_r + DW'(1);
            end else begin
              j_nxt = j_r + DW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    nr_m1_r    <= nr_m1_nxt;
    nk_m1_r    <= nk_m1_nxt;
    nc_m1_r    <= nc_m1_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
  end

  mme_mem #(.DEPTH(DEPTH), .AW(AW), .W(VAL_W)) u_a_mem (
    .clk   (clk),
    .wen   (we_a),
    .waddr (load_addr),
    .wdata (in_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_mem #(.DEPTH(DEPTH), .AW(AW), .W(VAL_W)) u_b_mem (
    .clk   (clk),
    .wen   (we_b),
    .waddr (load_addr),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mme_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (issue),
    .a_data  (a_rdata),
    .b_data  (b_rdata),
    .take    (acc_take),
    .acc_vld (acc_vld),
    .acc_sum (acc_sum)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - SUM_W - 2 * IDX_W){1'b0}},
                       out_sum_r, out_col_r, out_row_r};

  // A start transfer always launches a run.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start_xfer |=> (state_r == S_RUN))
    else $error("start transfer did not launch a run");

  // No new term enters the pipeline while a finished sum waits.
  a_no_issue_over_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc_vld && issue.vld))
    else $error("operand issued while accumulator holds a result");

  // The flagged final element sits at the bottom-right corner of C.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_last_r) |->
      ((out_row_r == IDX_W'(nr_m1_r)) && (out_col_r == IDX_W'(nc_m1_r))))
    else $error("last result flagged away from the final element");

  // A result waiting for the output register is taken only when it is free.
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    acc_take |-> (acc_vld && (!out_vld_r || out_tready)))
    else $error("accumulator taken while output register busy");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point matrix multiply engine.
// ----------------------------------------------------------------------------
// The bench loads A and B elements over the input stream and issues start
// commands under a range of size settings, including sizes that must clamp.
// A shadow copy of both element memories and the size registers is kept
// from the transfers seen at the ports. Every accepted start expands into
// the full list of expected C elements. Each C element that leaves the block
// is checked against the oldest expected one, field by field. Both streams
// see random gaps, and a watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb_top;
  import mme_pkg::*;

  localparam int DIM          = 8;     // matches the engine's MAX_DIM default
  localparam int RANDOM_ITEMS = 420;   // counted input items in the random part
  localparam int SETTLE       = 16;    // quiet cycles after the last C element
  localparam int IDLE_LIMIT   = 3000;  // cycles with no transfer before giving up

  // The fourth command code has no function in the engine and must be dropped.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One element of the product matrix as it appears on the result stream.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [SUM_W-1:0] sum;
    logic             last;
  } product_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tdata from bit 0: row[2:0], col[5:3], value[21:6], zero pad[23:22]
  logic [IN_DATA_W-1:0]  in_tdata;
  // in_tuser: cmd[1:0]
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_tdata from bit 0: out_row[2:0], out_col[5:3], dot_sum[40:6], pad[47:41]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // Shadow state of the engine, updated only from transfers at its ports.
  logic signed [VAL_W-1:0] a_mem [DIM*DIM];
  logic signed [VAL_W-1:0] b_mem [DIM*DIM];
  logic [CFG_W-1:0]        rows_cfg  = 4'd8;
  logic [CFG_W-1:0]        inner_cfg = 4'd8;
  logic [CFG_W-1:0]        cols_cfg  = 4'd8;

  // Stimulus bookkeeping: which entries hold a value, so that no multiply
  // ever reads an element that was never loaded.
  bit a_loaded [DIM*DIM];
  bit b_loaded [DIM*DIM];

  product_t    product_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned items_sent     = 0;
  bit          no_gaps        = 1'b0;

  matrix_multiply_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A size of zero behaves as one, and anything above the grid as the grid.
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] size);
    if (size == 0) begin
      return 1;
    end
    if (size > DIM) begin
      return DIM;
    end
    return size;
  endfunction

  // Expands one start into every C element, in row-major order. The sums are
  // formed in 64 bits and then cut to the 35-bit Q19.16 field.
  function automatic void predict_product();
    int unsigned nr;
    int unsigned nk;
    int unsigned nc;
    longint      acc;
    product_t    elem;
    nr = eff_dim(rows_cfg);
    nk = eff_dim(inner_cfg);
    nc = eff_dim(cols_cfg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_mem[i*DIM+k]) * longint'(b_mem[k*DIM+j]);
        end
        elem.row  = 3'(i);
        elem.col  = 3'(j);
        elem.sum  = acc[SUM_W-1:0];
        elem.last = (i == nr - 1) && (j == nc - 1);
        product_q.push_back(elem);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Port monitor: checks result transfers, then tracks input and
  // configuration transfers. Everything is sampled at the rising edge, while
  // the bench only drives on falling edges, so there is no race.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_products
    product_t got;
    product_t want;
    bit       moved;
    if (!rst_n) begin
      rows_cfg    = 4'd8;
      inner_cfg   = 4'd8;
      cols_cfg    = 4'd8;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved    = 1'b1;
        got.row  = out_tdata[2:0];
        got.col  = out_tdata[5:3];
        got.sum  = out_tdata[40:6];
        got.last = out_tlast;
        if (product_q.size() == 0) begin
          $error("C element [%0d][%0d] arrived with none expected", got.row, got.col);
          mismatch_count++;
        end else begin
          want = product_q.pop_front();
          if (got.row !== want.row) begin
            $error("out_row mismatch: expected %0d, got %0d", want.row, got.row);
            mismatch_count++;
          end
          if (got.col !== want.col) begin
            $error("out_col mismatch: expected %0d, got %0d", want.col, got.col);
            mismatch_count++;
          end
          if (got.sum !== want.sum) begin
            $error("dot_sum mismatch at C[%0d][%0d]: expected %0d, got %0d",
                   want.row, want.col, $signed(want.sum), $signed(got.sum));
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $error("last_result mismatch at C[%0d][%0d]: expected %0b, got %0b",
                   want.row, want.col, want.last, got.last);
            mismatch_count++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        case (in_tuser)
          CMD_LOAD_A: a_mem[in_tdata[2:0]*DIM + in_tdata[5:3]] = in_tdata[21:6];
          CMD_LOAD_B: b_mem[in_tdata[2:0]*DIM + in_tdata[5:3]] = in_tdata[21:6];
          CMD_START:  predict_product();
          default: ;
        endcase
      end

      if (cfg_wen) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_A_ROWS:    rows_cfg  = cfg_wdata;
          CFG_INNER_LEN: inner_cfg = cfg_wdata;
          CFG_B_COLS:    cols_cfg  = cfg_wdata;
          default: ;
        endcase
      end

      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // The watchdog only fires when no transfer of any kind has happened for a
  // long stretch, far beyond the slowest legal gap between transfers.
  initial begin : watchdog
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle length for either stream: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end
    if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Element values lean toward the Q8.8 extremes now and then.
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Size draws favor small matrices so most starts stay cheap; the tail
  // covers zero and the values above the grid that must clamp.
  function automatic logic [CFG_W-1:0] pick_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 4'($urandom_range(1, 3));
    end
    if (pick < 80) begin
      return 4'($urandom_range(4, 8));
    end
    if (pick < 86) begin
      return 4'd0;
    end
    return 4'($urandom_range(8, 15));
  endfunction

  // Presents one item and holds it until the engine takes it. When the next
  // item follows without a gap, valid simply stays high.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, value, col, row};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_LOAD_A) begin
      a_loaded[row*DIM+col] = 1'b1;
    end
    if (cmd == CMD_LOAD_B) begin
      b_loaded[row*DIM+col] = 1'b1;
    end
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  // Holds the sender back until every expected C element has been taken,
  // then waits out the pipeline so that the engine is truly idle.
  task automatic drain_products();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all three size registers on consecutive cycles.
  task automatic write_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                             input logic [CFG_W-1:0] cols);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_A_ROWS;
    cfg_wdata <= rows;
    @(negedge clk);
    cfg_index <= CFG_INNER_LEN;
    cfg_wdata <= inner;
    @(negedge clk);
    cfg_index <= CFG_B_COLS;
    cfg_wdata <= cols;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Loads every operand element that the current sizes will read and that
  // still holds no value, A or B first at random.
  task automatic load_operands();
    int unsigned nr;
    int unsigned nk;
    int unsigned nc;
    bit          b_first;
    nr      = eff_dim(rows_cfg);
    nk      = eff_dim(inner_cfg);
    nc      = eff_dim(cols_cfg);
    b_first = $urandom_range(0, 1);
    for (int pass = 0; pass < 2; pass++) begin
      if ((pass == 0) == b_first) begin
        for (int k = 0; k < nk; k++) begin
          for (int j = 0; j < nc; j++) begin
            if (!b_loaded[k*DIM+j]) begin
              send_item(CMD_LOAD_B, 3'(k), 3'(j), rand_value());
            end
          end
        end
      end else begin
        for (int i = 0; i < nr; i++) begin
          for (int k = 0; k < nk; k++) begin
            if (!a_loaded[i*DIM+k]) begin
              send_item(CMD_LOAD_A, 3'(i), 3'(k), rand_value());
            end
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A 1x1x1 product with the element extremes: largest times most negative,
  // then most negative squared.
  task automatic test_single_element();
    drain_products();
    write_sizes(4'd1, 4'd1, 4'd1);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h7fff);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_item(CMD_START, 3'd0, 3'd0, 16'h0000);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_item(CMD_START, 3'd7, 3'd7, 16'hffff);
  endtask

  // The unused command carries data aimed at A[0][0]; if the engine took it
  // as a load, the following start would show the changed element.
  task automatic test_ignored_command();
    send_item(CMD_UNUSED, 3'd0, 3'd0, 16'h1234);
    send_item(CMD_START, 3'd0, 3'd0, 16'h0000);
  endtask

  // All sizes zero must behave as a single element.
  task automatic test_size_clamp();
    drain_products();
    write_sizes(4'd0, 4'd0, 4'd0);
    send_item(CMD_START, 3'd0, 3'd0, 16'h0000);
  endtask

  // Eight products of the most negative element with itself give the
  // largest sum the result field has to hold. Row and column sizes of zero
  // clamp to one around a full-length dot product.
  task automatic test_sum_extremes();
    drain_products();
    write_sizes(4'd0, 4'd8, 4'd0);
    for (int k = 1; k < DIM; k++) begin
      send_item(CMD_LOAD_A, 3'd0, 3'(k), 16'h8000);
      send_item(CMD_LOAD_B, 3'(k), 3'd0, 16'h8000);
    end
    send_item(CMD_START, 3'd0, 3'd0, 16'h0000);
  endtask

  // Phases of random sizes. Each phase is a few well-formed sequences:
  // stray loads and dropped commands, the loads the product still needs,
  // then a start. Sizes only change once the engine has gone idle.
  task automatic test_random_products();
    int unsigned starts;
    int unsigned noise;
    int unsigned pick;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain_products();
      write_sizes(pick_size(), pick_size(), pick_size());
      no_gaps = ($urandom_range(0, 3) == 0);
      starts  = $urandom_range(1, 3);
      repeat (starts) begin
        noise = $urandom_range(0, 6);
        repeat (noise) begin
          pick = $urandom_range(0, 99);
          send_item((pick < 45) ? CMD_LOAD_A : (pick < 90) ? CMD_LOAD_B : CMD_UNUSED,
                    3'($urandom), 3'($urandom), rand_value());
        end
        load_operands();
        send_item(CMD_START, 3'($urandom), 3'($urandom), 16'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result-side backpressure: ready runs of random length, sometimes long,
  // broken by stalls drawn from the same mix as the sender's gaps.
  // --------------------------------------------------------------------------
  initial begin : result_backpressure
    int unsigned run;
    int unsigned stall;
    out_tready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) < 2) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(negedge clk);
      stall = gap_len();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_LOAD_A;
    cfg_wen   <= 1'b0;
    cfg_index <= CFG_A_ROWS;
    cfg_wdata <= '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_ignored_command();
    test_size_clamp();
    test_sum_extremes();
    test_random_products();

    // Wait for the last C element, then a quiet stretch in which any stray
    // result would still be caught.
    drain_products();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
